// ----- rtl/ssdrb_pkg.sv -----
// Shared types and codes for the SPI slave dual ring buffer.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package ssdrb_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_XCHG = 2'd0;  // SPI exchange finished
  localparam mode_t MODE_PUSH = 2'd1;  // host queues a transmit byte
  localparam mode_t MODE_POP  = 2'd2;  // host takes a received byte

  typedef struct packed {
    mode_t      mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic       shift_write;
    logic [7:0] shift_byte;
    logic       push_refused;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } out_t;

  // Decisions taken at acceptance, carried while the store read completes.
  typedef struct packed {
    logic shift_write;
    logic tx_pop;
    logic push_refused;
    logic rx_pop;
  } flight_t;

endpackage

// ----- rtl/spi_slave_dual_ring_buffer.sv -----
// SPI slave transmit and receive ring buffers held in two byte memories.
// Depends on ssdrb_pkg for the payload structs and mode codes.
//
//   channel | signals                        | payload
//   --------+--------------------------------+---------------------
//   input   | in_valid / in_ready / in_data  | ssdrb_pkg::in_t
//   output  | out_valid / out_ready / out_data | ssdrb_pkg::out_t
//
// A transaction is accepted every cycle while results are taken; its result passes
// through the registered read of the transmit or receive memory and then the output
// register. A stalled output register holds the in-flight transaction in the read
// stage and blocks further input.
// Reset clears the four ring indices and the handshake state at once; the
// memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module spi_slave_dual_ring_buffer #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ssdrb_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ssdrb_pkg::out_t out_data
);
  import ssdrb_pkg::*;

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam logic [IW-1:0] LAST = IW'(BUFFER_DEPTH - 2);

  logic [7:0] tx_mem [BUFFER_DEPTH];
  logic [7:0] rx_mem [BUFFER_DEPTH];
  logic [7:0] tx_rd;
  logic [7:0] rx_rd;

  logic [IW-1:0] tx_wr_idx, tx_rd_idx, rx_wr_idx, rx_rd_idx;
  logic [IW-1:0] tx_wr_idx_next, tx_rd_idx_next, rx_wr_idx_next, rx_rd_idx_next;

  logic    busy;
  flight_t flight;
  flight_t flight_next;

  logic accept, load, out_free;
  logic tx_empty, tx_full, rx_empty, rx_full;
  logic tx_wen, tx_ren, rx_wen, rx_ren;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    ring_next = (i == LAST) ? '0 : i + IW'(1);
  endfunction

  assign out_free = !out_valid || out_ready;
  assign in_ready = !busy || out_free;
  assign accept   = in_valid && in_ready;
  assign load     = busy && out_free;

  assign tx_empty = (tx_wr_idx == tx_rd_idx);
  assign rx_empty = (rx_wr_idx == rx_rd_idx);
  assign tx_full  = (ring_next(tx_wr_idx) == tx_rd_idx);
  assign rx_full  = (ring_next(rx_wr_idx) == rx_rd_idx);

  always_comb begin
    flight_next = '0;
    tx_wen = 1'b0;
    tx_ren = 1'b0;
    rx_wen = 1'b0;
    rx_ren = 1'b0;
    case (in_data.mode)
      MODE_XCHG: begin
        // A zero byte is not stored; a nonzero one forces a shift write, of 0x00 if the transmit ring is empty.
        rx_wen = (in_data.data_byte != 8'd0) && !rx_full;
        tx_ren = !tx_empty;
        flight_next.shift_write = (in_data.data_byte != 8'd0) || !tx_empty;
        flight_next.tx_pop      = !tx_empty;
      end
      MODE_PUSH: begin
        tx_wen = !tx_full;
        flight_next.push_refused = tx_full;
      end
      MODE_POP: begin
        rx_ren = !rx_empty;
        flight_next.rx_pop = !rx_empty;
      end
      default: begin
      end
    endcase
  end

  assign tx_wr_idx_next = (accept && tx_wen) ? ring_next(tx_wr_idx) : tx_wr_idx;
  assign tx_rd_idx_next = (accept && tx_ren) ? ring_next(tx_rd_idx) : tx_rd_idx;
  assign rx_wr_idx_next = (accept && rx_wen) ? ring_next(rx_wr_idx) : rx_wr_idx;
  assign rx_rd_idx_next = (accept && rx_ren) ? ring_next(rx_rd_idx) : rx_rd_idx;

  // Each ring is written and read by different modes, so a single transaction
  // never touches the same entry twice and no forwarding is needed.
  always_ff @(posedge clk) begin
    if (accept && tx_wen) begin
      tx_mem[tx_wr_idx] <= in_data.data_byte;
    end
    if (accept && tx_ren) begin
      tx_rd <= tx_mem[tx_rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rx_wen) begin
      rx_mem[rx_wr_idx] <= in_data.data_byte;
    end
    if (accept && rx_ren) begin
      rx_rd <= rx_mem[rx_rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_wr_idx <= '0;
      tx_rd_idx <= '0;
      rx_wr_idx <= '0;
      rx_rd_idx <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      tx_wr_idx <= tx_wr_idx_next;
      tx_rd_idx <= tx_rd_idx_next;
      rx_wr_idx <= rx_wr_idx_next;
      rx_rd_idx <= rx_rd_idx_next;
      if (accept) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flight <= flight_next;
    end
    if (load) begin
      out_data.shift_write  <= flight.shift_write;
      out_data.shift_byte   <= flight.tx_pop ? tx_rd : 8'd0;
      out_data.push_refused <= flight.push_refused;
      out_data.rx_valid     <= flight.rx_pop;
      out_data.rx_byte      <= flight.rx_pop ? rx_rd : 8'd0;
    end
  end

endmodule

// ----- rtl/ssdrb_checker.sv -----
// Port-level checks for the SPI slave dual ring buffer, bound to the top level.
// Depends on ssdrb_pkg for the payload structs.
`timescale 1ns / 1ps

module ssdrb_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input ssdrb_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input ssdrb_pkg::out_t out_data
);
  import ssdrb_pkg::*;

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An accepted transaction shows its result once the output register is free to load it.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("result missing after acceptance");

  // A nonzero shift byte is only reported together with a shift register write.
  a_shift_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.shift_byte != 8'd0) |-> out_data.shift_write)
    else $error("shift byte without shift write");

  // A popped byte is zero unless the pop found data.
  a_rx_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.rx_byte != 8'd0) |-> out_data.rx_valid)
    else $error("rx byte without rx valid");

  // Results of different modes never mix in one transaction.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({out_data.shift_write, out_data.push_refused,
                              out_data.rx_valid}) <= 1)
    else $error("result flags from several modes");

endmodule

bind spi_slave_dual_ring_buffer ssdrb_checker u_ssdrb_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the SPI slave dual ring buffer.
// Depends on ssdrb_pkg and spi_slave_dual_ring_buffer; needs no other files.
`timescale 1ns / 1ps

module testbench;
  import ssdrb_pkg::*;

  localparam mode_t MODE_UNUSED = 2'd3;   // decoded as a no-op by the block
  localparam int RING_SLOTS = 63;         // indices wrap over DEPTH-1 slots
  localparam int PHASE_ITEMS = 400;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 8;

  // Tracks both rings and queues the result that each transaction should give.
  class ring_scoreboard;
    logic [7:0] tx_mem [RING_SLOTS];
    logic [7:0] rx_mem [RING_SLOTS];
    logic [5:0] tx_wr, tx_rd, rx_wr, rx_rd;
    out_t expected_q[$];
    int errors;
    int results_seen;

    function new();
      tx_wr = '0;
      tx_rd = '0;
      rx_wr = '0;
      rx_rd = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function logic [5:0] advance(logic [5:0] idx);
      return (idx == RING_SLOTS - 1) ? 6'd0 : idx + 6'd1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(in_t x);
      out_t r;
      r = '0;
      case (x.mode)
        MODE_XCHG: begin
          // A nonzero byte forces a shift write even if the rx ring drops it.
          if (x.data_byte != 8'h00) begin
            if (advance(rx_wr) != rx_rd) begin
              rx_mem[rx_wr] = x.data_byte;
              rx_wr = advance(rx_wr);
            end
            r.shift_write = 1'b1;
          end
          if (tx_wr != tx_rd) begin
            r.shift_byte = tx_mem[tx_rd];
            r.shift_write = 1'b1;
            tx_rd = advance(tx_rd);
          end
        end
        MODE_PUSH: begin
          if (advance(tx_wr) == tx_rd) begin
            r.push_refused = 1'b1;
          end else begin
            tx_mem[tx_wr] = x.data_byte;
            tx_wr = advance(tx_wr);
          end
        end
        MODE_POP: begin
          if (rx_wr != rx_rd) begin
            r.rx_byte = rx_mem[rx_rd];
            r.rx_valid = 1'b1;
            rx_rd = advance(rx_rd);
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      if (errors < 40)
        $display("mismatch at result %0d: %s got %h expected %h",
                 results_seen, what, got, want);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result without a pending transaction", got.shift_byte, 8'h00);
        results_seen++;
        return;
      end
      want = expected_q.pop_front();
      if (got.shift_write !== want.shift_write)
        report_mismatch("shift_write", 8'(got.shift_write), 8'(want.shift_write));
      if (got.shift_byte !== want.shift_byte)
        report_mismatch("shift_byte", got.shift_byte, want.shift_byte);
      if (got.push_refused !== want.push_refused)
        report_mismatch("push_refused", 8'(got.push_refused), 8'(want.push_refused));
      if (got.rx_valid !== want.rx_valid)
        report_mismatch("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
      if (got.rx_byte !== want.rx_byte)
        report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
      results_seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  ring_scoreboard sb = new();

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int phase_sent = 0;

  spi_slave_dual_ring_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge where they complete.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_input(in_data);
      if (out_valid && out_ready)
        sb.check_result(out_data);
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(mode_t m, logic [7:0] d);
    in_t x;
    x.mode = m;
    x.data_byte = d;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (in_ready !== 1'b1);
    phase_sent++;
  endtask

  function automatic int burst_length();
    return ($urandom_range(3) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 30);
  endfunction

  // One sequence: long runs of one kind fill or drain a ring, the rest is mixed.
  task automatic run_burst();
    int kind;
    int len;
    mode_t m;
    kind = $urandom_range(9);
    len = burst_length();
    for (int i = 0; i < len; i++) begin
      if (phase_sent == 150 && stall_pct == 0 && sender_idle_pct == 0 && hold_requests == 0)
        hold_requests <= hold_requests + 1;
      case (kind)
        0, 1: send_item(MODE_PUSH, 8'($urandom_range(255)));
        2, 3: send_item(MODE_XCHG,
                        ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        4, 5: send_item(MODE_POP, 8'($urandom_range(255)));
        9: send_item(($urandom_range(1) == 0) ? MODE_UNUSED : MODE_XCHG, 8'h00);
        default: begin
          m = ($urandom_range(19) == 0) ? MODE_UNUSED : mode_t'($urandom_range(2));
          send_item(m, 8'($urandom_range(255)));
        end
      endcase
    end
  endtask

  task automatic run_directed();
    send_item(MODE_POP, 8'h00);       // pop from an empty receive ring
    send_item(MODE_XCHG, 8'h00);      // zero byte, nothing to send: no write
    send_item(MODE_XCHG, 8'hFF);      // nonzero byte with empty transmit ring
    send_item(MODE_UNUSED, 8'hFF);
    send_item(MODE_PUSH, 8'hFF);
    send_item(MODE_PUSH, 8'h00);
    send_item(MODE_PUSH, 8'h5A);
    send_item(MODE_XCHG, 8'h00);      // zero byte still pops the transmit ring
    send_item(MODE_XCHG, 8'h01);
    send_item(MODE_XCHG, 8'h80);
    send_item(MODE_POP, 8'hFF);
    send_item(MODE_POP, 8'h00);
    send_item(MODE_POP, 8'hAA);
    send_item(MODE_POP, 8'h55);
    send_item(MODE_UNUSED, 8'h00);
    send_item(MODE_PUSH, 8'h7F);
    send_item(MODE_XCHG, 8'hFE);
    send_item(MODE_POP, 8'h00);
  endtask

  initial begin
    int idle_table [4];
    int stall_table [4];
    idle_table = '{0, 84, 0, 14};
    stall_table = '{0, 0, 84, 14};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_table[p];
      stall_pct <= stall_table[p];
      phase_sent = 0;
      if (p == 0)
        run_directed();
      while (phase_sent < PHASE_ITEMS)
        run_burst();
      in_valid <= 1'b0;
      // Sender pauses here until every expected result has come back.
      while (sb.pending() != 0)
        @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- spi_slave_dual_ring_buffer.f -----
rtl/ssdrb_pkg.sv
rtl/spi_slave_dual_ring_buffer.sv
rtl/ssdrb_checker.sv
verif/testbench.sv
